@@ sv/iira_pkg.sv @@
// Package for the indexed insert/remove array: sizes, command and status codes, sequencer states.
`default_nettype none
package iira_pkg;

	localparam int DEPTH   = 16;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LEN_W   = $clog2(DEPTH + 1);

	localparam int CMD_W   = 3;
	localparam int POS_W   = 5;
	localparam int DATA_W  = 32;
	localparam int SIZE_W  = 5;
	localparam int OLEN_W  = 5;
	localparam int STAT_W  = 2;

	// common width for index and length compares
	localparam int CMP_W   = (LEN_W > POS_W) ? LEN_W : POS_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_READ    = 3'd0,
		CMD_WRITE   = 3'd1,
		CMD_INSERT  = 3'd2,
		CMD_REMOVE  = 3'd3,
		CMD_RESIZE  = 3'd4,
		CMD_REALLOC = 3'd5,
		CMD_CLEAR   = 3'd6
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_RD_WAIT,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

@@ sv/iira_cmd_if.sv @@
// Command channel: valid/ready handshake with the command payload.
`default_nettype none
interface iira_cmd_if;
	import iira_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         command;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] item_value;
	logic [SIZE_W-1:0]        new_size;

	modport source (output valid, output command, output position, output item_value,
		output new_size, input ready);
	modport sink (input valid, input command, input position, input item_value,
		input new_size, output ready);
endinterface
`default_nettype wire

@@ sv/iira_rsp_if.sv @@
// Response channel: valid/ready handshake with the result payload.
`default_nettype none
interface iira_rsp_if;
	import iira_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] read_data;
	logic [OLEN_W-1:0]        current_length;
	logic [STAT_W-1:0]        status;

	modport source (output valid, output read_data, output current_length, output status,
		input ready);
	modport sink (input valid, input read_data, input current_length, input status,
		output ready);
endinterface
`default_nettype wire

@@ sv/iira_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module iira_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ sv/indexed_insert_remove_array.sv @@
// Top level of the indexed insert/remove array: command sequencer, valid bits and result register.
//
// Bounded list of signed 32-bit words in a RAM of DEPTH entries with a current
// length. One command is taken at a time; cmd.ready is high only while the
// sequencer is idle. A command goes from its transfer through an execute state
// to a done state, which loads its result into the response register once that
// register is free (read: with a wait state for the RAM data between), except
// insert and remove, which move one entry at a time, a read state then a write
// state, through the single RAM port pair and one shared index step/compare unit. The
// sequencer is idle again in the cycle after the load, and that cycle can already
// carry the next command transfer. The response register lets a
// new command start while the previous result still waits on rsp.ready. Each
// entry has a valid bit in flip-flops that reset clears at once; an entry that is
// not valid reads as zero, so reset, resize, reallocate and clear need no sweep.
// A bad index, an oversized length or an insert into a full list leaves
// everything unchanged and reports its status.
`default_nettype none
module indexed_insert_remove_array (
	input  wire logic clk,
	input  wire logic arst_n,
	iira_cmd_if.sink   cmd,
	iira_rsp_if.source rsp
);
	import iira_pkg::*;

	state_t                   state_q, state_d;
	logic [CMD_W-1:0]         cmd_q;
	logic [CMP_W-1:0]         pos_q;
	logic signed [DATA_W-1:0] val_q;
	logic [CMP_W-1:0]         req_q;
	logic [LEN_W-1:0]         len_q;
	logic [LEN_W-1:0]         idx_q;
	logic [DEPTH-1:0]         vld_q;
	logic                     src_vld_q;
	logic signed [DATA_W-1:0] rd_data_q;
	status_t                  status_q;
	status_t                  exec_status;

	logic                     rsp_valid_q;
	logic signed [DATA_W-1:0] rsp_data_q;
	logic [OLEN_W-1:0]        rsp_len_q;
	status_t                  rsp_status_q;

	// RAM port
	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [DATA_W-1:0] ram_wdata, ram_rdata;

	// compares and the shared index step
	logic [CMP_W-1:0] len_ext, idx_ext, step_ext;
	logic [LEN_W-1:0] idx_step;
	logic             is_ins, pos_lt_len, pos_gt_len, full, req_big, at_end, out_free;
	logic             cmd_xfer;

	assign cmd_xfer   = cmd.valid && cmd.ready;
	assign out_free   = !rsp_valid_q || rsp.ready;

	assign len_ext    = CMP_W'(len_q);
	assign idx_ext    = CMP_W'(idx_q);
	assign is_ins     = (cmd_q == CMD_INSERT);
	// insert walks down from the tail, remove walks up from the hole
	assign idx_step   = is_ins ? (idx_q - LEN_W'(1)) : (idx_q + LEN_W'(1));
	assign step_ext   = CMP_W'(idx_step);
	assign pos_lt_len = (pos_q < len_ext);
	assign pos_gt_len = (pos_q > len_ext);
	assign full       = (len_ext >= CMP_W'(DEPTH));
	assign req_big    = (req_q > CMP_W'(DEPTH));
	assign at_end     = is_ins ? (idx_ext == pos_q) : (step_ext == len_ext);

	// status of the captured command; range check wins over the full check
	always_comb begin
		exec_status = ST_OK;
		case (cmd_q)
			CMD_READ, CMD_WRITE, CMD_REMOVE: begin
				if (!pos_lt_len) exec_status = ST_RANGE;
			end
			CMD_INSERT: begin
				if (pos_gt_len) exec_status = ST_RANGE;
				else if (full) exec_status = ST_FULL;
			end
			CMD_RESIZE, CMD_REALLOC: begin
				if (req_big) exec_status = ST_RANGE;
			end
			default: ;
		endcase
	end

	iira_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_xfer) state_d = S_EXEC;
			end
			S_EXEC: begin
				case (cmd_q)
					CMD_READ:   state_d = pos_lt_len ? S_RD_WAIT : S_DONE;
					CMD_INSERT: state_d = (!pos_gt_len && !full) ? S_SHIFT_RD : S_DONE;
					CMD_REMOVE: state_d = pos_lt_len ? S_SHIFT_RD : S_DONE;
					default:    state_d = S_DONE;
				endcase
			end
			S_RD_WAIT:  state_d = S_DONE;
			S_SHIFT_RD: state_d = at_end ? S_DONE : S_SHIFT_WR;
			S_SHIFT_WR: state_d = S_SHIFT_RD;
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default:    state_d = S_IDLE;
		endcase
	end

	// RAM controls
	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = pos_q[ADDR_W-1:0];
		ram_raddr = pos_q[ADDR_W-1:0];
		ram_wdata = val_q;
		case (state_q)
			S_EXEC: begin
				if (cmd_q == CMD_READ && pos_lt_len) ram_re = 1'b1;
				if (cmd_q == CMD_WRITE && pos_lt_len) ram_we = 1'b1;
			end
			S_SHIFT_RD: begin
				if (at_end) begin
					// insert drops the new value into the opened slot
					ram_we = is_ins;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = idx_step[ADDR_W-1:0];
				end
			end
			S_SHIFT_WR: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q[ADDR_W-1:0];
				ram_wdata = ram_rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			vld_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_EXEC: begin
					rd_data_q <= '0;
					status_q  <= exec_status;
					src_vld_q <= vld_q[pos_q[ADDR_W-1:0]];
					case (cmd_q)
						CMD_WRITE: begin
							if (pos_lt_len) vld_q[pos_q[ADDR_W-1:0]] <= 1'b1;
						end
						CMD_INSERT: begin
							idx_q <= len_q;
						end
						CMD_REMOVE: begin
							idx_q <= pos_q[LEN_W-1:0];
						end
						CMD_RESIZE: begin
							if (!req_big) begin
								// entries past the new length read as zero
								for (int i = 0; i < DEPTH; i++) begin
									if (CMP_W'(i) >= req_q) vld_q[i] <= 1'b0;
								end
								len_q <= req_q[LEN_W-1:0];
							end
						end
						CMD_REALLOC: begin
							if (!req_big) begin
								vld_q <= '0;
								len_q <= req_q[LEN_W-1:0];
							end
						end
						CMD_CLEAR: begin
							vld_q <= '0;
							len_q <= '0;
						end
						default: ;
					endcase
				end
				S_RD_WAIT: begin
					rd_data_q <= src_vld_q ? ram_rdata : '0;
				end
				S_SHIFT_RD: begin
					if (at_end) begin
						if (is_ins) begin
							vld_q[pos_q[ADDR_W-1:0]] <= 1'b1;
							len_q <= len_q + LEN_W'(1);
						end else begin
							vld_q[idx_q[ADDR_W-1:0]] <= 1'b0;
							len_q <= len_q - LEN_W'(1);
						end
					end else begin
						src_vld_q <= vld_q[idx_step[ADDR_W-1:0]];
					end
				end
				S_SHIFT_WR: begin
					vld_q[idx_q[ADDR_W-1:0]] <= src_vld_q;
					idx_q <= idx_step;
				end
				S_DONE: begin
					if (out_free) begin
						rsp_data_q   <= rd_data_q;
						rsp_len_q    <= len_ext[OLEN_W-1:0];
						rsp_status_q <= status_q;
					end
				end
				default: ;
			endcase
		end
	end

	// command capture on transfer
	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			cmd_q <= cmd.command;
			pos_q <= CMP_W'(cmd.position);
			val_q <= cmd.item_value;
			req_q <= CMP_W'(cmd.new_size);
		end
	end

	assign cmd.ready          = (state_q == S_IDLE);
	assign rsp.valid          = rsp_valid_q;
	assign rsp.read_data      = rsp_data_q;
	assign rsp.current_length = rsp_len_q;
	assign rsp.status         = rsp_status_q;

endmodule
`default_nettype wire

@@ verif/iira_list_checker.sv @@
// Checker for the indexed insert/remove array: watches both channels, predicts each result and compares it.
module iira_list_checker (
	input  logic       clk,
	input  logic       arst_n,
	iira_cmd_if        cmd,
	iira_rsp_if        rsp,
	output int         errors,
	output int         pending,
	output int         tracked_length
);
	import iira_pkg::*;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic [OLEN_W-1:0]        length;
		status_t                  status;
	} list_result_t;

	logic signed [DATA_W-1:0] shadow_store [DEPTH];
	int unsigned              shadow_len = 0;
	list_result_t             awaited_results [$];
	int                       fail_count = 0;
	int                       queued_count = 0;

	assign errors         = fail_count;
	assign pending        = queued_count;
	assign tracked_length = shadow_len;

	task automatic flag_mismatch(input string what);
		$display("%0t: mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	// applies one command to the shadow list and returns the response it must produce
	function automatic list_result_t run_list_op(input logic [CMD_W-1:0] op,
		input int unsigned pos, input logic signed [DATA_W-1:0] val, input int unsigned size);
		list_result_t res;
		int unsigned  i;
		res.data   = '0;
		res.status = ST_OK;
		case (op)
			CMD_READ: begin
				if (pos < shadow_len) res.data = shadow_store[pos];
				else res.status = ST_RANGE;
			end
			CMD_WRITE: begin
				if (pos < shadow_len) shadow_store[pos] = val;
				else res.status = ST_RANGE;
			end
			CMD_INSERT: begin
				if (pos > shadow_len) begin
					res.status = ST_RANGE;
				end else if (shadow_len >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					for (i = shadow_len; i > pos; i--)
						shadow_store[i] = shadow_store[i-1];
					shadow_store[pos] = val;
					shadow_len++;
				end
			end
			CMD_REMOVE: begin
				if (pos < shadow_len) begin
					for (i = pos; i + 1 < shadow_len; i++)
						shadow_store[i] = shadow_store[i+1];
					shadow_len--;
					shadow_store[shadow_len] = '0;
				end else begin
					res.status = ST_RANGE;
				end
			end
			CMD_RESIZE: begin
				if (size > DEPTH) begin
					res.status = ST_RANGE;
				end else begin
					for (i = size; i < DEPTH; i++)
						shadow_store[i] = '0;
					shadow_len = size;
				end
			end
			CMD_REALLOC: begin
				if (size > DEPTH) begin
					res.status = ST_RANGE;
				end else begin
					foreach (shadow_store[k]) shadow_store[k] = '0;
					shadow_len = size;
				end
			end
			CMD_CLEAR: begin
				foreach (shadow_store[k]) shadow_store[k] = '0;
				shadow_len = 0;
			end
			default: ;
		endcase
		res.length = shadow_len[OLEN_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		if (!arst_n) begin
			foreach (shadow_store[k]) shadow_store[k] = '0;
			shadow_len = 0;
			awaited_results.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (awaited_results.size() == 0) begin
					flag_mismatch("response with no command outstanding");
				end else begin
					want = awaited_results.pop_front();
					if (rsp.read_data !== want.data)
						flag_mismatch($sformatf("read_data %0d, expected %0d",
							rsp.read_data, want.data));
					if (rsp.current_length !== want.length)
						flag_mismatch($sformatf("current_length %0d, expected %0d",
							rsp.current_length, want.length));
					if (rsp.status !== want.status)
						flag_mismatch($sformatf("status %0d, expected %0d",
							rsp.status, want.status));
				end
			end
			if (cmd.valid && cmd.ready)
				awaited_results.push_back(run_list_op(cmd.command, 32'(cmd.position),
					cmd.item_value, 32'(cmd.new_size)));
		end
		queued_count = awaited_results.size();
	end

endmodule

@@ verif/tb_indexed_insert_remove_array.sv @@
// Testbench top for the indexed insert/remove array: clock, reset, command stimulus and verdict.
module tb_indexed_insert_remove_array;
	import iira_pkg::*;

	// command 7 has no operation behind it; the block must answer it with no change
	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
	localparam int RANDOM_ITEMS  = 1800;
	localparam int IDLE_PCT      = 19;
	localparam int HOLD_CYCLES   = 300;
	// covers the longest command, a full-length shift, with some margin
	localparam int DRAIN_CYCLES  = 2*DEPTH + 8;

	localparam logic signed [DATA_W-1:0] MAX_WORD = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] MIN_WORD = 32'sh8000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	iira_cmd_if cmd_ch();
	iira_rsp_if rsp_ch();

	int errors;
	int pending;
	int tracked_length;

	// both sides stop idling during this stretch
	logic calm = 1'b0;
	// raised once by the stimulus; the receiver then holds off on its own count
	logic want_hold = 1'b0;

	indexed_insert_remove_array DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch.sink),
		.rsp    (rsp_ch.source)
	);

	iira_list_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd_ch),
		.rsp            (rsp_ch),
		.errors         (errors),
		.pending        (pending),
		.tracked_length (tracked_length)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop in case a handshake never completes
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	// Receiver: ready changes at the falling edge. Random stalls, one long
	// hold-off on request so that the response register fills and the block
	// pushes back on the command side.
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (want_hold && !hold_done) begin
				if (hold_left == 0) hold_left = HOLD_CYCLES;
				hold_left--;
				if (hold_left == 0) hold_done = 1'b1;
				rsp_ch.ready = 1'b0;
			end else begin
				rsp_ch.ready = calm || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// One command transfer. Payload and valid change only at the falling edge;
	// returns right after the rising edge that completed the transfer, so valid
	// is never dropped and raised inside the same step.
	task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] pos,
		input logic signed [DATA_W-1:0] val, input logic [SIZE_W-1:0] size);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			cmd_ch.valid = 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid      = 1'b1;
		cmd_ch.command    = op;
		cmd_ch.position   = pos;
		cmd_ch.item_value = val;
		cmd_ch.new_size   = size;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	initial begin
		int                       roll;
		int                       len;
		bit                       growing;
		logic [CMD_W-1:0]         op;
		logic [POS_W-1:0]         pos;
		logic signed [DATA_W-1:0] val;
		logic [SIZE_W-1:0]        size;

		growing           = 1'b1;
		cmd_ch.valid      = 1'b0;
		cmd_ch.command    = CMD_READ;
		cmd_ch.position   = '0;
		cmd_ch.item_value = '0;
		cmd_ch.new_size   = '0;

		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// Directed: read, write, remove and insert on an empty list, extremes of
		// the word, range and full checks, growing and shrinking resize,
		// reallocate, clear and the unused command.
		send_cmd(CMD_READ,    5'd0,  '0,        5'd0);
		send_cmd(CMD_WRITE,   5'd0,  MAX_WORD,  5'd0);
		send_cmd(CMD_REMOVE,  5'd0,  '0,        5'd0);
		send_cmd(CMD_INSERT,  5'd1,  MAX_WORD,  5'd0);  // past the end
		send_cmd(CMD_INSERT,  5'd0,  MAX_WORD,  5'd0);
		send_cmd(CMD_INSERT,  5'd1,  MIN_WORD,  5'd0);
		send_cmd(CMD_INSERT,  5'd0,  -32'sd1,   5'd0);
		send_cmd(CMD_READ,    5'd0,  '0,        5'd0);
		send_cmd(CMD_READ,    5'd2,  '0,        5'd0);
		send_cmd(CMD_WRITE,   5'd2,  '0,        5'd0);
		send_cmd(CMD_REMOVE,  5'd1,  '0,        5'd0);
		send_cmd(CMD_RESIZE,  5'd0,  '0,        5'd17); // just over capacity
		send_cmd(CMD_RESIZE,  5'd0,  '0,        5'd31);
		send_cmd(CMD_RESIZE,  5'd0,  '0,        5'd16); // grow: new entries zero
		send_cmd(CMD_READ,    5'd15, '0,        5'd0);
		send_cmd(CMD_INSERT,  5'd16, MIN_WORD,  5'd0);  // full
		send_cmd(CMD_INSERT,  5'd31, MIN_WORD,  5'd0);  // range wins over full
		send_cmd(CMD_RESIZE,  5'd0,  '0,        5'd1);  // shrink clears the tail
		send_cmd(CMD_RESIZE,  5'd0,  '0,        5'd4);
		send_cmd(CMD_READ,    5'd3,  '0,        5'd0);
		send_cmd(CMD_REALLOC, 5'd0,  '0,        5'd5);
		send_cmd(CMD_READ,    5'd0,  '0,        5'd0);
		send_cmd(CMD_REALLOC, 5'd0,  '0,        5'd31);
		send_cmd(CMD_CLEAR,   5'd31, MAX_WORD,  5'd31);
		send_cmd(CMD_UNUSED,  5'd31, MAX_WORD,  5'd31);

		// Random: the mix swings between a growing phase (mostly inserts) and a
		// shrinking one (mostly removes) so the list keeps sweeping between empty
		// and full. Most indexes are legal for the current length; the rest span
		// the whole field.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 600) want_hold = 1'b1;
			if (n == 1200) begin
				// sender pause: let every outstanding result drain
				@(negedge clk);
				cmd_ch.valid = 1'b0;
				wait (pending == 0);
			end
			calm = (n >= 900 && n < 1100);

			len = tracked_length;
			if (len < 3) growing = 1'b1;
			else if (len >= DEPTH && $urandom_range(0, 9) == 0) growing = 1'b0;
			else if ($urandom_range(0, 99) < 2) growing = !growing;

			roll = $urandom_range(0, 99);
			if (growing) begin
				if (roll < 40)      op = CMD_INSERT;
				else if (roll < 55) op = CMD_WRITE;
				else if (roll < 72) op = CMD_READ;
				else if (roll < 82) op = CMD_REMOVE;
				else if (roll < 90) op = CMD_RESIZE;
				else if (roll < 93) op = CMD_REALLOC;
				else if (roll < 95) op = CMD_CLEAR;
				else if (roll < 97) op = CMD_UNUSED;
				else                op = CMD_INSERT;
			end else begin
				if (roll < 15)      op = CMD_INSERT;
				else if (roll < 30) op = CMD_WRITE;
				else if (roll < 50) op = CMD_READ;
				else if (roll < 85) op = CMD_REMOVE;
				else if (roll < 92) op = CMD_RESIZE;
				else if (roll < 95) op = CMD_REALLOC;
				else if (roll < 98) op = CMD_CLEAR;
				else                op = CMD_UNUSED;
			end

			if ($urandom_range(0, 99) < 12) pos = POS_W'($urandom_range(0, 31));
			else if (op == CMD_INSERT)      pos = POS_W'($urandom_range(0, len));
			else if (len > 0)               pos = POS_W'($urandom_range(0, len - 1));
			else                            pos = 5'd0;

			roll = $urandom_range(0, 99);
			if (roll < 10)      val = MIN_WORD;
			else if (roll < 20) val = MAX_WORD;
			else if (roll < 25) val = -32'sd1;
			else if (roll < 30) val = '0;
			else                val = $urandom;

			if ($urandom_range(0, 99) < 15) size = SIZE_W'($urandom_range(0, 31));
			else                            size = SIZE_W'($urandom_range(0, DEPTH));

			send_cmd(op, pos, val, size);
		end

		@(negedge clk);
		cmd_ch.valid = 1'b0;
		calm = 1'b1;
		wait (pending == 0);
		// any late or extra response shows up within the longest command time
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
